@@ design/shp3x3_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package shp3x3_pkg;

    // field and register widths
    localparam int CH_W       = 8;
    localparam int PIX_W      = 3 * CH_W;
    localparam int CFG_W      = 11;
    localparam int ROW_W      = CFG_W + 1;
    localparam int MIN_DIM    = 3;

    // default geometry
    localparam int MAX_WIDTH_DEF = 1024;
    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

    // apb port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // output buffer
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef logic [PIX_W-1:0] t_pixel;

    // one line memory entry: row above and current row at the same column
    typedef struct packed {
        t_pixel upper;
        t_pixel middle;
    } t_line_pair;

    // per-item control carried down the pipeline
    typedef struct packed {
        logic has_out;
        logic border;
        logic last;
    } t_meta;

    // one result word, red in the low bits
    typedef struct packed {
        logic   last;
        t_pixel pix;
    } t_result;

    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_reg_idx;

endpackage

`default_nettype wire

@@ design/sharpen_3x3_convolution.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel    dir  width  contents
// s_axis     in   24+1   tdata: red, green, blue; tuser: fill flag
// m_axis     out  24+1   tdata: red, green, blue; tlast: final pixel of frame
// apb        in   32     reg 0 image_width at 0x0, reg 1 image_height at 0x4
//
// one pixel word is taken every cycle while s_axis_tready is high; the item
// that completes a window passes read, window shift and sharpen into buffer
// the rate is set by the line memory, which does one read and one write a cycle
// s_axis_tready falls only when the four-entry output buffer plus the two
// words in flight would overflow it, so a stalled sink blocks after four words
// reset clears counters, window, pipeline and buffer; the line memory is not
// cleared, needs no clearing pass and is usable right after reset

module sharpen_3x3_convolution #(
    parameter int MAX_WIDTH = shp3x3_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // stream in
    input  wire logic                            s_axis_tvalid,
    output      logic                            s_axis_tready,
    input  wire logic [shp3x3_pkg::PIX_W-1:0]    s_axis_tdata,  // red, green, blue
    input  wire logic                            s_axis_tuser,  // is_fill
    // stream out
    output      logic                            m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output      logic [shp3x3_pkg::PIX_W-1:0]    m_axis_tdata,  // red, green, blue
    output      logic                            m_axis_tlast,  // frame_last
    // configuration
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [shp3x3_pkg::APB_AW-1:0]   paddr,
    input  wire logic [shp3x3_pkg::APB_DW-1:0]   pwdata,
    output      logic [shp3x3_pkg::APB_DW-1:0]   prdata,
    output      logic                            pready
);

    localparam int CW    = $clog2(MAX_WIDTH);       // column index bits
    localparam int WCW   = $clog2(MAX_WIDTH + 1);   // holds the width itself
    localparam int CFG_W = shp3x3_pkg::CFG_W;
    localparam int ROW_W = shp3x3_pkg::ROW_W;
    localparam int DW    = shp3x3_pkg::APB_DW;
    localparam int MIN_D = shp3x3_pkg::MIN_DIM;

    // ---------------------------------------------------------------- registers
    logic [CFG_W-1:0] r_width;
    logic [CFG_W-1:0] r_height;
    logic             cfg_wr;
    logic [CW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;
    logic [CW-1:0]    n_col;
    logic [ROW_W-1:0] n_row;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= shp3x3_pkg::WIDTH_RESET;
            r_height <= shp3x3_pkg::HEIGHT_RESET;
        end else if (cfg_wr) begin
            unique case (shp3x3_pkg::t_reg_idx'(paddr[2]))
                shp3x3_pkg::REG_IMAGE_WIDTH:  r_width  <= pwdata[CFG_W-1:0];
                shp3x3_pkg::REG_IMAGE_HEIGHT: r_height <= pwdata[CFG_W-1:0];
                default:                      r_width  <= r_width;
            endcase
        end
    end

    always_comb begin
        unique case (shp3x3_pkg::t_reg_idx'(paddr[2]))
            shp3x3_pkg::REG_IMAGE_WIDTH:  prdata = DW'(r_width);
            shp3x3_pkg::REG_IMAGE_HEIGHT: prdata = DW'(r_height);
            default:                      prdata = '0;
        endcase
    end

    // ------------------------------------------------------- effective geometry
    logic [WCW-1:0]   w_eff;
    logic [CW-1:0]    w_m1;
    logic [ROW_W-1:0] h_eff;

    always_comb begin
        if (r_width < CFG_W'(MIN_D)) begin
            w_eff = WCW'(MIN_D);
        end else if (int'(r_width) > MAX_WIDTH) begin
            w_eff = WCW'(MAX_WIDTH);
        end else begin
            w_eff = WCW'(r_width);
        end
        w_m1  = CW'(w_eff - WCW'(1));
        h_eff = (r_height < CFG_W'(MIN_D)) ? ROW_W'(MIN_D) : ROW_W'(r_height);
    end

    // ---------------------------------------------- position of the taken word
    logic              acc;
    logic [CW-1:0]     c_eff;
    logic [ROW_W-1:0]  qr;
    logic [CW-1:0]     qc;
    logic              q_has;
    shp3x3_pkg::t_meta meta;
    shp3x3_pkg::t_pixel px;

    assign acc = s_axis_tvalid & s_axis_tready;
    assign px  = s_axis_tuser ? '0 : s_axis_tdata;

    always_comb begin
        c_eff = (WCW'(r_col) >= w_eff) ? '0 : r_col;
        // the result that this word completes lies one row and one pixel back
        if (c_eff == '0) begin
            q_has = (r_row >= ROW_W'(2));
            qr    = r_row - ROW_W'(2);
            qc    = w_m1;
        end else begin
            q_has = (r_row >= ROW_W'(1));
            qr    = r_row - ROW_W'(1);
            qc    = c_eff - CW'(1);
        end
        meta.has_out = q_has && (qr < h_eff);
        meta.last    = meta.has_out && (qr == h_eff - ROW_W'(1)) && (qc == w_m1);
        meta.border  = (qr == '0) || (qr == h_eff - ROW_W'(1)) ||
                       (qc == '0) || (qc == w_m1);
        if (meta.last) begin
            n_col = '0;
            n_row = '0;
        end else if (c_eff == w_m1) begin
            n_col = '0;
            n_row = r_row + ROW_W'(1);
        end else begin
            n_col = c_eff + CW'(1);
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (cfg_wr) begin
            r_col <= '0;                        // any write restarts the frame
            r_row <= '0;
        end else if (acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ----------------------------------------------- stage 1: line memory read
    logic                   r_s1_valid;
    logic [CW-1:0]          r_s1_addr;
    shp3x3_pkg::t_pixel     r_s1_px;
    shp3x3_pkg::t_meta      r_s1_meta;
    logic                   r_s1_fwd;
    shp3x3_pkg::t_pixel     r_fwd_top;
    shp3x3_pkg::t_pixel     r_fwd_mid;
    shp3x3_pkg::t_line_pair rd_data;
    shp3x3_pkg::t_line_pair wr_data;
    shp3x3_pkg::t_pixel     top1;
    shp3x3_pkg::t_pixel     mid1;

    shp3x3_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (acc),
        .i_rd_addr (c_eff),
        .o_rd_data (rd_data),
        .i_wr_en   (r_s1_valid),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (wr_data)
    );

    // a word right after frame end reads column 0 while it is being written back
    assign top1 = r_s1_fwd ? r_fwd_top : rd_data.upper;
    assign mid1 = r_s1_fwd ? r_fwd_mid : rd_data.middle;
    assign wr_data.upper  = mid1;
    assign wr_data.middle = r_s1_px;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_fwd   <= 1'b0;
        end else begin
            r_s1_valid <= acc;
            r_s1_fwd   <= acc && r_s1_valid && (r_s1_addr == c_eff);
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_addr <= c_eff;
            r_s1_px   <= px;
            r_s1_meta <= meta;
            r_fwd_top <= mid1;
            r_fwd_mid <= r_s1_px;
        end
    end

    // ------------------------------------------ stage 2: window and sharpening
    logic               r_s2_valid;
    shp3x3_pkg::t_meta  r_s2_meta;
    shp3x3_pkg::t_pixel k_pix;

    shp3x3_kernel u_kernel (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_shift  (r_s1_valid),
        .i_top    (top1),
        .i_mid    (mid1),
        .i_bot    (r_s1_px),
        .i_border (r_s2_meta.border),
        .o_pix    (k_pix)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_s2_meta <= r_s1_meta;
        end
    end

    // ---------------------------------------------------------- output buffer
    logic                                 push;
    shp3x3_pkg::t_result                  push_data;
    shp3x3_pkg::t_result                  out_data;
    logic [shp3x3_pkg::FIFO_CW-1:0]       fifo_count;
    logic [shp3x3_pkg::FIFO_CW:0]         credit_used;

    assign push           = r_s2_valid & r_s2_meta.has_out;
    assign push_data.pix  = k_pix;
    assign push_data.last = r_s2_meta.last;

    shp3x3_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (out_data),
        .o_count (fifo_count)
    );

    assign m_axis_tdata = out_data.pix;
    assign m_axis_tlast = out_data.last;

    // buffered words plus words in flight must leave room for one more
    assign credit_used   = (shp3x3_pkg::FIFO_CW + 1)'(fifo_count)
                         + (shp3x3_pkg::FIFO_CW + 1)'(r_s1_valid)
                         + (shp3x3_pkg::FIFO_CW + 1)'(r_s2_valid);
    assign s_axis_tready = (credit_used < (shp3x3_pkg::FIFO_CW + 1)'(shp3x3_pkg::FIFO_DEPTH));

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (fifo_count < shp3x3_pkg::FIFO_CW'(shp3x3_pkg::FIFO_DEPTH)))
        else $error("output buffer overflow");

    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (WCW'(r_col) < w_eff))
        else $error("column count beyond row width");

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row <= h_eff + ROW_W'(1)))
        else $error("row count beyond frame tail");

    a_fwd_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && r_s1_valid && (r_s1_addr == c_eff)) |-> (c_eff == '0))
        else $error("line memory clash away from frame restart");
`endif

endmodule

`default_nettype wire

@@ design/shp3x3_line_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none

module shp3x3_line_mem #(
    parameter int DEPTH = shp3x3_pkg::MAX_WIDTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rd_en,
    input  wire logic [AW-1:0]          i_rd_addr,
    output      shp3x3_pkg::t_line_pair o_rd_data,
    input  wire logic                   i_wr_en,
    input  wire logic [AW-1:0]          i_wr_addr,
    input  wire shp3x3_pkg::t_line_pair i_wr_data
);

    shp3x3_pkg::t_line_pair r_mem [DEPTH];
    shp3x3_pkg::t_line_pair r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read returns old data on an address clash; the caller forwards
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ design/shp3x3_kernel.sv @@
`timescale 1ns / 1ps
`default_nettype none

module shp3x3_kernel (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_shift,
    input  wire shp3x3_pkg::t_pixel i_top,
    input  wire shp3x3_pkg::t_pixel i_mid,
    input  wire shp3x3_pkg::t_pixel i_bot,
    input  wire logic               i_border,
    output      shp3x3_pkg::t_pixel o_pix
);

    localparam int CW = shp3x3_pkg::CH_W;

    shp3x3_pkg::t_pixel r_win [3][3];

    // 5*center minus the four neighbors, clamped to 0..255
    function automatic logic [CW-1:0] sharpen_chan(
        input logic [CW-1:0] ctr,
        input logic [CW-1:0] up,
        input logic [CW-1:0] lf,
        input logic [CW-1:0] rt,
        input logic [CW-1:0] dn
    );
        logic [CW+2:0] five;
        logic [CW+2:0] negs;
        logic [CW+2:0] diff;
        five = {1'b0, ctr, 2'b00} + (CW+3)'(ctr);
        negs = (CW+3)'(up) + (CW+3)'(lf) + (CW+3)'(rt) + (CW+3)'(dn);
        diff = five - negs;
        if (five < negs) begin
            sharpen_chan = '0;
        end else if (diff[CW+2:CW] != 3'b000) begin
            sharpen_chan = '1;
        end else begin
            sharpen_chan = diff[CW-1:0];
        end
    endfunction

    // rows: 0 above, 1 middle, 2 newest; column 2 is the newest
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[k][j] <= '0;
                end
            end
        end else if (i_shift) begin
            for (int k = 0; k < 3; k++) begin
                r_win[k][0] <= r_win[k][1];
                r_win[k][1] <= r_win[k][2];
            end
            r_win[0][2] <= i_top;
            r_win[1][2] <= i_mid;
            r_win[2][2] <= i_bot;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (i_border) begin
                o_pix[CW*k +: CW] = r_win[1][1][CW*k +: CW];
            end else begin
                o_pix[CW*k +: CW] = sharpen_chan(r_win[1][1][CW*k +: CW],
                                                 r_win[0][1][CW*k +: CW],
                                                 r_win[1][0][CW*k +: CW],
                                                 r_win[1][2][CW*k +: CW],
                                                 r_win[2][1][CW*k +: CW]);
            end
        end
    end

endmodule

`default_nettype wire

@@ design/shp3x3_out_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module shp3x3_out_fifo (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_push,
    input  wire shp3x3_pkg::t_result                  i_data,
    output      logic                                 o_valid,
    input  wire logic                                 i_ready,
    output      shp3x3_pkg::t_result                  o_data,
    output      logic [shp3x3_pkg::FIFO_CW-1:0]       o_count
);

    localparam int DEPTH = shp3x3_pkg::FIFO_DEPTH;
    localparam int PW    = shp3x3_pkg::FIFO_PW;
    localparam int CNTW  = shp3x3_pkg::FIFO_CW;

    shp3x3_pkg::t_result r_mem [DEPTH];
    logic [PW-1:0]       r_wr_ptr;
    logic [PW-1:0]       r_rd_ptr;
    logic [CNTW-1:0]     r_count;
    logic                pop;

    assign o_valid = (r_count != '0);
    assign pop     = o_valid & i_ready;
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + CNTW'(1);
                2'b01:   r_count <= r_count - CNTW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire
